// ===== src/pfdb_pkg.sv =====
// Shared constants and codes for the page frame deframer and bitmap store.
package pfdb_pkg;

    // Default geometry
    localparam int BUFFER_WIDTH_DEF = 128;
    localparam int FRAME_BYTES_DEF  = 1024;
    localparam int IMAGE_ROWS       = 64;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'h7b;
    localparam logic [7:0] HDR_SECOND = 8'hff;

    // Column mask seed (MSB-first pixel order)
    localparam logic [7:0] MASK_MSB = 8'h80;

    // Item function codes
    localparam logic [1:0] FN_START = 2'd0;
    localparam logic [1:0] FN_BYTE  = 2'd1;
    localparam logic [1:0] FN_TICK  = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    // Parser phase codes
    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_RECV    = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_TIMEOUT = 3'd4;

    // Configuration register indexes (taken from paddr[2])
    localparam logic REG_FIRST_WAIT = 1'b0;
    localparam logic REG_GAP_WAIT   = 1'b1;

    // Configuration reset values
    localparam logic [7:0] FIRST_WAIT_RST = 8'd100;
    localparam logic [7:0] GAP_WAIT_RST   = 8'd10;

endpackage

// ===== src/pfdb_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module pfdb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/page_frame_deframer_to_bitmap.sv =====
// Top level: serial frame deframer that paints data columns into a bitmap RAM.
//
// After reset the bitmap RAM is cleared one byte per cycle (BUFFER_WIDTH/8*64
// bytes, 1024 at the default width) while s_ready stays low; APB writes are
// taken throughout. Items are handled one at a time. A start, tick, header or
// ignored byte transaction passes through the result state (ST_DONE) into the
// output register; a read first passes through ST_READ for the registered RAM
// read. A stored data byte goes through row sequencing (ST_ROW), in which its
// eight pixel rows are read-modify-written one per cycle through the single
// write port of the bitmap RAM, with the read of the next row overlapping the
// write of the previous one, then through ST_DONE to load the result. s_ready
// rises again as the result is loaded. A finished result waits in the output
// register while the next transaction is accepted and worked on; if that one
// finishes first, it holds in the result stage with s_ready low.
module page_frame_deframer_to_bitmap
    import pfdb_pkg::*;
#(
    parameter int BUFFER_WIDTH = BUFFER_WIDTH_DEF,
    parameter int FRAME_BYTES  = FRAME_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [7:0]  s_rx_byte,
    input  logic [9:0]  s_read_address,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_phase,
    output logic [7:0]  m_read_data,
    output logic [10:0] m_bytes_received,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ROW_BYTES   = BUFFER_WIDTH / 8;
    localparam int STORE_BYTES = ROW_BYTES * IMAGE_ROWS;
    localparam int PAGE_STRIDE = ROW_BYTES * 8;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int CW          = $clog2(FRAME_BYTES + 1);

    // Sequencer state codes
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_ROW   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Configuration
    logic [7:0]    first_wait_reg;
    logic [7:0]    gap_wait_reg;

    // Parser state
    logic [2:0]    state_reg, state_next;
    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    wait_reg, wait_next;
    logic [6:0]    col_reg, col_next;
    logic [2:0]    page_reg, page_next;
    logic [CW-1:0] count_reg, count_next;

    // Clear sweep and row sequencer
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [3:0]    row_cnt_reg, row_cnt_next;
    logic [AW-1:0] row_addr_reg, row_addr_next;
    logic [AW-1:0] wr_addr_reg, wr_addr_next;
    logic [7:0]    byte_reg, byte_next;
    logic [7:0]    mask_reg, mask_next;
    logic [7:0]    rd_reg, rd_next;

    // Output register
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_phase_reg, m_phase_next;
    logic [7:0]    m_rd_reg, m_rd_next;
    logic [10:0]   m_count_reg, m_count_next;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          s_take;
    logic          cfg_write;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;
    assign m_valid          = m_valid_reg;
    assign m_phase          = m_phase_reg;
    assign m_read_data      = m_rd_reg;
    assign m_bytes_received = m_count_reg;

    // APB register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_FIRST_WAIT: prdata = {24'd0, first_wait_reg};
            REG_GAP_WAIT:   prdata = {24'd0, gap_wait_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_wait_reg <= FIRST_WAIT_RST;
            gap_wait_reg   <= GAP_WAIT_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_FIRST_WAIT: first_wait_reg <= pwdata[7:0];
                REG_GAP_WAIT:   gap_wait_reg   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Bitmap RAM
    pfdb_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM port steering: clear sweep, pixel row write-back, item reads
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = byte_reg[0] ? (ram_rdata | mask_reg) : (ram_rdata & ~mask_reg);
        ram_raddr = (state_reg == ST_ROW) ? row_addr_reg : AW'(s_read_address);
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_ROW && row_cnt_reg != 4'd0) begin
            ram_we = 1'b1;
        end
    end

    // Parser update on accepted transactions
    always_comb begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        col_next   = col_reg;
        page_next  = page_reg;
        count_next = count_reg;
        if (s_take) begin
            unique case (s_func)
                FN_START: begin
                    phase_next = PH_HUNT1;
                    col_next   = '0;
                    page_next  = '0;
                    count_next = '0;
                    wait_next  = first_wait_reg;
                    if (first_wait_reg == 8'd0) begin
                        phase_next = PH_TIMEOUT;
                    end
                end
                FN_BYTE: begin
                    if (phase_reg < PH_DONE && wait_reg != 8'd0) begin
                        unique case (phase_reg)
                            PH_HUNT1: begin
                                if (s_rx_byte == HDR_FIRST) begin
                                    phase_next = PH_HUNT2;
                                    wait_next  = gap_wait_reg;
                                    if (gap_wait_reg == 8'd0) begin
                                        phase_next = PH_TIMEOUT;
                                    end
                                end
                            end
                            PH_HUNT2: begin
                                if (s_rx_byte == HDR_SECOND) begin
                                    phase_next = PH_RECV;
                                    wait_next  = gap_wait_reg;
                                    if (gap_wait_reg == 8'd0) begin
                                        phase_next = PH_TIMEOUT;
                                    end
                                end else begin
                                    phase_next = PH_HUNT1;
                                end
                            end
                            PH_RECV: begin
                                col_next = col_reg + 7'd1;
                                if (col_reg == 7'h7f) begin
                                    page_next = page_reg + 3'd1;
                                end
                                if (count_reg < CW'(FRAME_BYTES)) begin
                                    count_next = count_reg + CW'(1);
                                end
                                if (count_next >= CW'(FRAME_BYTES)) begin
                                    phase_next = PH_DONE;
                                end
                                wait_next = gap_wait_reg;
                                if (gap_wait_reg == 8'd0 && phase_next < PH_DONE) begin
                                    phase_next = PH_TIMEOUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                FN_TICK: begin
                    if (phase_reg < PH_TIMEOUT && wait_reg != 8'd0) begin
                        wait_next = wait_reg - 8'd1;
                        if (wait_reg == 8'd1 && phase_reg < PH_DONE) begin
                            phase_next = PH_TIMEOUT;
                        end
                    end
                end
                FN_READ: ;
                default: ;
            endcase
        end
    end

    // Sequencer: clear sweep, item dispatch, row read-modify-write, result
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        row_cnt_next  = row_cnt_reg;
        row_addr_next = row_addr_reg;
        wr_addr_next  = wr_addr_reg;
        byte_next     = byte_reg;
        mask_next     = mask_reg;
        rd_next       = rd_reg;
        m_valid_next  = m_valid_reg;
        m_phase_next  = m_phase_reg;
        m_rd_next     = m_rd_reg;
        m_count_next  = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(STORE_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_take) begin
                    rd_next    = '0;
                    state_next = ST_DONE;
                    if (s_func == FN_READ) begin
                        state_next = ST_READ;
                    end else if (s_func == FN_BYTE && phase_reg == PH_RECV
                                 && wait_reg != 8'd0) begin
                        // latch the column for the eight-row pixel update
                        state_next    = ST_ROW;
                        row_cnt_next  = '0;
                        row_addr_next = AW'(32'(page_reg) * PAGE_STRIDE
                                            + 32'(col_reg[6:3]));
                        byte_next     = s_rx_byte;
                        mask_next     = MASK_MSB >> col_reg[2:0];
                    end
                end
            end
            ST_READ: begin
                rd_next = ram_rdata;
                if (32'(s_read_address) >= STORE_BYTES) begin
                    rd_next = '0;
                end
                state_next = ST_DONE;
            end
            ST_ROW: begin
                // read row n while writing back row n-1
                wr_addr_next  = row_addr_reg;
                row_addr_next = row_addr_reg + AW'(ROW_BYTES);
                row_cnt_next  = row_cnt_reg + 4'd1;
                if (row_cnt_reg != 4'd0) begin
                    byte_next = byte_reg >> 1;
                end
                if (row_cnt_reg == 4'd8) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_phase_next = phase_reg;
                    m_rd_next    = rd_reg;
                    m_count_next = 11'(count_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            phase_reg    <= PH_TIMEOUT;
            wait_reg     <= '0;
            col_reg      <= '0;
            page_reg     <= '0;
            count_reg    <= '0;
            row_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            phase_reg    <= phase_next;
            wait_reg     <= wait_next;
            col_reg      <= col_next;
            page_reg     <= page_next;
            count_reg    <= count_next;
            row_cnt_reg  <= row_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_addr_reg <= row_addr_next;
        wr_addr_reg  <= wr_addr_next;
        byte_reg     <= byte_next;
        mask_reg     <= mask_next;
        rd_reg       <= rd_next;
        m_phase_reg  <= m_phase_next;
        m_rd_reg     <= m_rd_next;
        m_count_reg  <= m_count_next;
    end

    // Checks
    a_complete_full: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> count_reg == CW'(FRAME_BYTES))
        else $error("complete phase without a full frame");

    a_ram_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_ROW))
        else $error("bitmap write outside clear sweep or row update");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROW |-> row_cnt_reg <= 4'd8)
        else $error("row sequencer overran eight rows");

    a_row_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROW && row_cnt_reg == 4'd8) |=> state_reg == ST_DONE)
        else $error("row update did not finish into result");

endmodule
